FILE: hdl/neighbor_ring_average_3x3_top_defines.svh
// Assertion macros shared by the checker of the neighbor ring average block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef NEIGHBOR_RING_AVERAGE_3X3_TOP_DEFINES_SVH
`define NEIGHBOR_RING_AVERAGE_3X3_TOP_DEFINES_SVH

// same-cycle implication
`define NRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nra assertion failed");

// next-cycle implication
`define NRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nra assertion failed");

`endif

FILE: hdl/nra_pkg.sv
// Package of the neighbor ring average block: widths, defaults and limits.
// No dependencies; used by the interfaces, the cell, the top and the checker.
package nra_pkg;

    localparam int MAX_SIDE_DEF   = 1024;
    localparam int PIXEL_BITS_DEF = 8;
    localparam int CFG_W          = 11;
    localparam int OUT_W          = 11;
    localparam int OUT_MAX        = 2047;
    localparam int MIN_SIDE       = 3;
    localparam int SIDE_RESET     = 3;
    localparam int WIN_ROWS       = 3;

endpackage

FILE: hdl/nra_ifs.sv
// Stream interfaces of the neighbor ring average block: pixel in, result out,
// side register write. Depends on nra_pkg.
interface nra_pix_if #(
    parameter int PIXEL_BITS = nra_pkg::PIXEL_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface nra_res_if ();
    logic                       valid;
    logic                       ready;
    logic [nra_pkg::OUT_W-1:0]  avg_times_eight;
    logic                       frame_last;

    modport source (output valid, output avg_times_eight, output frame_last, input ready);
    modport sink   (input valid, input avg_times_eight, input frame_last, output ready);
endinterface

interface nra_cfg_if ();
    logic                       valid;
    logic                       ready;
    logic [nra_pkg::CFG_W-1:0]  image_side;

    modport source (output valid, output image_side, input ready);
    modport sink   (input valid, input image_side, output ready);
endinterface

FILE: hdl/nra_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies; holds the line stores.
module nra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/nra_cell.sv
// One window column cell: holds three vertically stacked pixels and passes
// them to the next cell on each shift. Depends on nra_pkg.
module nra_cell #(
    parameter int PIXEL_BITS = nra_pkg::PIXEL_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_shift,
    input  logic [nra_pkg::WIN_ROWS-1:0][PIXEL_BITS-1:0] i_col,
    output logic [nra_pkg::WIN_ROWS-1:0][PIXEL_BITS-1:0] o_col
);
    import nra_pkg::*;

    logic [WIN_ROWS-1:0][PIXEL_BITS-1:0] r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;
endmodule

FILE: hdl/neighbor_ring_average_3x3_top.sv
// Top level of the neighbor ring average block (3x3 box sum without center).
// Depends on nra_pkg, nra_ifs, nra_ram and nra_cell.
//
// Usage:
//   i_pix  : one pixel per beat, raster order, square image of image_side.
//   o_res  : one beat per interior position, avg_times_eight is the sum of
//            the eight neighbors (mean with 3 fraction bits); frame_last
//            marks the last interior result of the image.
//   i_cfg  : writes image_side (clamped to 3..MAX_SIDE); also restarts the
//            frame. Write only while the block is idle. Always ready.
//   Throughput: one pixel per cycle while o_res.ready is high; the line RAMs
//   are read in the accept cycle and written when the pixel leaves stage 1.
//   Result path: the result for a pixel that completes a window is
//   registered by the RAM read, the window shift and the sum register.
//   Reset: side 3, counters and window cleared; the line RAMs need no
//   clearing, their stale entries only feed border positions.
//   Stall: when o_res.ready is low, the result holds and the pipeline keeps
//   taking pixels until its two internal stages are full.
module neighbor_ring_average_3x3_top #(
    parameter int MAX_SIDE   = nra_pkg::MAX_SIDE_DEF,
    parameter int PIXEL_BITS = nra_pkg::PIXEL_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nra_pix_if.sink    i_pix,
    nra_cfg_if.sink    i_cfg,
    nra_res_if.source  o_res
);
    import nra_pkg::*;

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int RAW_W = PIXEL_BITS + 3;
    localparam int SUM_W = (RAW_W > OUT_W) ? RAW_W : OUT_W;

    logic [CFG_W-1:0]      r_side;
    logic [SW-1:0]         side_eff;
    logic [SW-1:0]         side_last;
    logic [CW-1:0]         r_col;
    logic [CW-1:0]         r_row;
    logic                  col_end;
    logic                  row_end;

    logic                  r_s1_valid;
    logic [PIXEL_BITS-1:0] r_s1_px;
    logic [CW-1:0]         r_s1_col;
    logic                  r_s1_emit;
    logic                  r_s1_last;
    logic                  r_s2_valid;
    logic                  r_s2_last;
    logic                  r_o_valid;
    logic [OUT_W-1:0]      r_o_sum;
    logic                  r_o_last;

    logic                  ready0;
    logic                  ready1;
    logic                  ready2;
    logic                  fire0;
    logic                  fire1;
    logic                  fire2;

    logic [PIXEL_BITS-1:0] up_rd;
    logic [PIXEL_BITS-1:0] mid_rd;

    logic [WIN_ROWS-1:0][PIXEL_BITS-1:0] col_in;
    logic [WIN_ROWS-1:0][PIXEL_BITS-1:0] w0;
    logic [WIN_ROWS-1:0][PIXEL_BITS-1:0] w1;
    logic [WIN_ROWS-1:0][PIXEL_BITS-1:0] w2;

    logic [SUM_W-1:0]      sum;
    logic [OUT_W-1:0]      sum_sat;

    always_comb begin
        if (int'(r_side) < MIN_SIDE) begin
            side_eff = SW'(MIN_SIDE);
        end else if (int'(r_side) > MAX_SIDE) begin
            side_eff = SW'(MAX_SIDE);
        end else begin
            side_eff = SW'(r_side);
        end
    end

    assign side_last = side_eff - SW'(1);
    assign col_end   = (SW'(r_col) == side_last);
    assign row_end   = (SW'(r_row) == side_last);

    assign ready2 = !r_o_valid || o_res.ready;
    assign ready1 = !r_s2_valid || ready2;
    assign ready0 = !r_s1_valid || ready1;
    assign fire0  = i_pix.valid && ready0;
    assign fire1  = r_s1_valid && ready1;
    assign fire2  = r_s2_valid && ready2;

    assign i_pix.ready = ready0;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= CFG_W'(SIDE_RESET);
            r_col  <= '0;
            r_row  <= '0;
        end else if (i_cfg.valid) begin
            r_side <= i_cfg.image_side;
            r_col  <= '0;
            r_row  <= '0;
        end else if (fire0) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + CW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // stage 1: line RAM read data lines up with the pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (fire0) begin
            r_s1_valid <= 1'b1;
        end else if (fire1) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire0) begin
            r_s1_px   <= i_pix.pixel;
            r_s1_col  <= r_col;
            r_s1_emit <= (r_row >= CW'(2)) && (r_col >= CW'(2));
            r_s1_last <= col_end && row_end;
        end
    end

    nra_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_SIDE)
    ) u_ram_up (
        .i_clk   (i_clk),
        .i_we    (fire1),
        .i_waddr (r_s1_col),
        .i_wdata (mid_rd),
        .i_re    (fire0),
        .i_raddr (r_col),
        .o_rdata (up_rd)
    );

    nra_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_SIDE)
    ) u_ram_mid (
        .i_clk   (i_clk),
        .i_we    (fire1),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_px),
        .i_re    (fire0),
        .i_raddr (r_col),
        .o_rdata (mid_rd)
    );

    // window: three column cells, newest first
    assign col_in[0] = up_rd;
    assign col_in[1] = mid_rd;
    assign col_in[2] = r_s1_px;

    nra_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell0 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_shift (fire1), .i_col (col_in), .o_col (w0)
    );

    nra_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_shift (fire1), .i_col (w0), .o_col (w1)
    );

    nra_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell2 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_shift (fire1), .i_col (w1), .o_col (w2)
    );

    // stage 2: window holds a complete neighborhood
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (fire1) begin
            r_s2_valid <= r_s1_emit;
        end else if (fire2) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire1) begin
            r_s2_last <= r_s1_last;
        end
    end

    assign sum = SUM_W'(w0[0]) + SUM_W'(w0[1]) + SUM_W'(w0[2])
               + SUM_W'(w1[0]) + SUM_W'(w1[2])
               + SUM_W'(w2[0]) + SUM_W'(w2[1]) + SUM_W'(w2[2]);

    assign sum_sat = (sum > SUM_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : sum[OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (fire2) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire2) begin
            r_o_sum  <= sum_sat;
            r_o_last <= r_s2_last;
        end
    end

    assign o_res.valid           = r_o_valid;
    assign o_res.avg_times_eight = r_o_sum;
    assign o_res.frame_last      = r_o_last;
endmodule

FILE: hdl/nra_checker.sv
// Port-level checker of the neighbor ring average block, bound to the top.
// Depends on nra_pkg and neighbor_ring_average_3x3_top_defines.svh.
`include "neighbor_ring_average_3x3_top_defines.svh"

module nra_checker #(
    parameter int PIXEL_BITS = nra_pkg::PIXEL_BITS_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_pix_ready,
    input logic                      i_res_valid,
    input logic                      i_res_ready,
    input logic [nra_pkg::OUT_W-1:0] i_res_avg,
    input logic                      i_res_last
);
    import nra_pkg::*;

    localparam int BOUND_RAW = 8 * ((1 << PIXEL_BITS) - 1);
    localparam int BOUND     = (BOUND_RAW > OUT_MAX) ? OUT_MAX : BOUND_RAW;

    `NRA_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_avg) && $stable(i_res_last))
    `NRA_ASSERT_IMP(a_ready_when_empty, i_clk, i_rst_n, !i_res_valid, i_pix_ready)
    `NRA_ASSERT_IMP(a_sum_bound, i_clk, i_rst_n, i_res_valid, i_res_avg <= OUT_W'(BOUND))
    `NRA_ASSERT_IMP(a_quiet_after_reset, i_clk, i_rst_n, $rose(i_rst_n), !i_res_valid)
endmodule

bind neighbor_ring_average_3x3_top nra_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_nra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_ready (i_pix.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_avg   (o_res.avg_times_eight),
    .i_res_last  (o_res.frame_last)
);
